// ===== hw/rtl/sstwr_pkg.sv =====
// ============================================================================
// sstwr_pkg
// Shared types and constants for the two-wire seven-segment refresher.
// ============================================================================
package sstwr_pkg;

   localparam int DIGITS = 6;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 3;
   localparam int BYTE_W   = 8;
   localparam int BRIGHT_W = 3;
   localparam int CSR_IDX_W = 2;

   // Request action codes
   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REFRESH = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_BRIGHT  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_CMD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_CMD   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_BASE  = 2'd3;

   // Register reset values
   localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST = 3'd0;
   localparam logic [BYTE_W-1:0]   DATA_CMD_RST   = 8'h40;
   localparam logic [BYTE_W-1:0]   ADDR_CMD_RST   = 8'hC0;
   localparam logic [BYTE_W-1:0]   CTRL_BASE_RST  = 8'h88;
   localparam logic [BYTE_W-1:0]   DIGIT_RST      = 8'h40;

   // Frame segment codes
   localparam logic [1:0] SEG_START = 2'd0;
   localparam logic [1:0] SEG_BYTE  = 2'd1;
   localparam logic [1:0] SEG_STOP  = 2'd2;

   // Write counts inside a segment (last offset)
   localparam logic [4:0] COND_LAST = 5'd3;   // four writes per start/stop
   localparam logic [4:0] BYTE_LAST = 5'd26;  // 8 bits x 3 + ack x 3
   localparam logic [4:0] ACK_FIRST = 5'd24;
   localparam logic [1:0] PH_LAST   = 2'd2;
   localparam logic [2:0] LAST_BYTE = 3'd7;   // address cmd + six digits

   typedef logic [BYTE_W-1:0] byte_type;

endpackage

// ===== hw/rtl/seven_segment_two_wire_refresher_top.sv =====
// ============================================================================
// seven_segment_two_wire_refresher_top
// Two-wire seven-segment display refresher: one pin write per tick.
// ============================================================================
// Each request transaction is handled on acceptance and produces exactly one
// response transaction; a new request can be taken every cycle as long as the
// response register is empty or being drained in the same cycle (req_ready is
// !rsp_valid || rsp_ready). Throughput is therefore one transaction per clock,
// set by the single response register. Tick transactions step a running frame
// by one pin write: start (clk low, dio high, clk high, dio low), bytes sent
// LSB first with three writes per bit plus three for the unsampled ack clock,
// and stop (clk low, dio low, clk high, dio high). A refresh frame sends the
// data command, then the address command followed by digits 3,4,5,0,1,2
// (232 ticks); a brightness frame sends control_base | brightness (35 ticks).
// Start requests while a frame is busy are dropped. Configuration registers
// are written through csr_write_enable / csr_index / csr_wdata with no wait.
// ============================================================================
module seven_segment_two_wire_refresher_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sstwr_pkg::ACTION_W-1:0]     req_action,
   input  logic [sstwr_pkg::INDEX_W-1:0]      req_digit_index,
   input  logic [sstwr_pkg::BYTE_W-1:0]       req_segments,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_clk_level,
   output logic                               rsp_dio_level,
   output logic                               rsp_busy_res,
   output logic                               rsp_frame_done,
   // configuration port
   input  logic                               csr_write_enable,
   input  logic [sstwr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sstwr_pkg::BYTE_W-1:0]       csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [sstwr_pkg::BRIGHT_W-1:0] brightness_ff;
   sstwr_pkg::byte_type            data_cmd_ff;
   sstwr_pkg::byte_type            addr_cmd_ff;
   sstwr_pkg::byte_type            ctrl_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= sstwr_pkg::BRIGHTNESS_RST;
         data_cmd_ff   <= sstwr_pkg::DATA_CMD_RST;
         addr_cmd_ff   <= sstwr_pkg::ADDR_CMD_RST;
         ctrl_base_ff  <= sstwr_pkg::CTRL_BASE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sstwr_pkg::CSR_BRIGHTNESS: brightness_ff <= csr_wdata[sstwr_pkg::BRIGHT_W-1:0];
            sstwr_pkg::CSR_DATA_CMD:   data_cmd_ff   <= csr_wdata;
            sstwr_pkg::CSR_ADDR_CMD:   addr_cmd_ff   <= csr_wdata;
            sstwr_pkg::CSR_CTRL_BASE:  ctrl_base_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Frame state
   //   seg_ff  : which part of the frame (start / byte / stop)
   //   off_ff  : write offset inside that part
   //   ph_ff   : bit phase inside a byte (clk low, data, clk high)
   //   byte_ff : byte number in the frame (0 = first command byte)
   // ---------------------------------------------------------------------
   sstwr_pkg::byte_type digit_ff [sstwr_pkg::DIGITS];
   sstwr_pkg::byte_type digit_in [sstwr_pkg::DIGITS];

   logic                clock_pin_ff,   clock_pin_in;
   logic                data_pin_ff,    data_pin_in;
   logic                active_ff,      active_in;
   logic                refresh_ff,     refresh_in;
   logic [1:0]          seg_ff,         seg_in;
   logic [4:0]          off_ff,         off_in;
   logic [1:0]          ph_ff,          ph_in;
   logic [2:0]          byte_ff,        byte_in;
   sstwr_pkg::byte_type shift_ff,       shift_in;

   logic                rsp_valid_ff,   rsp_valid_in;
   logic                rsp_clk_ff,     rsp_clk_in;
   logic                rsp_dio_ff,     rsp_dio_in;
   logic                rsp_busy_ff,    rsp_busy_in;
   logic                rsp_done_ff,    rsp_done_in;

   logic                accept;
   logic                done;
   sstwr_pkg::byte_type fetch_byte;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Byte fetched at the first write of each byte. Digits go out in the
   // order 3,4,5,0,1,2 after the address command.
   always_comb begin
      if (!refresh_ff) begin
         fetch_byte = ctrl_base_ff | {5'd0, brightness_ff};
      end else begin
         unique case (byte_ff)
            3'd0: fetch_byte = data_cmd_ff;
            3'd1: fetch_byte = addr_cmd_ff;
            3'd2: fetch_byte = digit_ff[3];
            3'd3: fetch_byte = digit_ff[4];
            3'd4: fetch_byte = digit_ff[5];
            3'd5: fetch_byte = digit_ff[0];
            3'd6: fetch_byte = digit_ff[1];
            3'd7: fetch_byte = digit_ff[2];
            default: fetch_byte = '0;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < sstwr_pkg::DIGITS; i++) begin
         digit_in[i] = digit_ff[i];
      end
      clock_pin_in = clock_pin_ff;
      data_pin_in  = data_pin_ff;
      active_in    = active_ff;
      refresh_in   = refresh_ff;
      seg_in       = seg_ff;
      off_in       = off_ff;
      ph_in        = ph_ff;
      byte_in      = byte_ff;
      shift_in     = shift_ff;
      done         = 1'b0;

      if (accept) begin
         unique case (req_action)
            sstwr_pkg::ACT_TICK: begin
               if (active_ff) begin
                  // pin write for this tick
                  unique case (seg_ff)
                     sstwr_pkg::SEG_BYTE: begin
                        unique case (ph_ff)
                           2'd0: begin
                              clock_pin_in = 1'b0;
                              if (off_ff == 5'd0) shift_in = fetch_byte;
                           end
                           2'd1: begin
                              data_pin_in = (off_ff >= sstwr_pkg::ACK_FIRST) ? 1'b1
                                                                             : shift_ff[0];
                           end
                           default: begin
                              clock_pin_in = 1'b1;
                              shift_in     = {1'b0, shift_ff[sstwr_pkg::BYTE_W-1:1]};
                           end
                        endcase
                     end
                     default: begin
                        // start and stop differ only in the data levels
                        unique case (off_ff[1:0])
                           2'd0: clock_pin_in = 1'b0;
                           2'd1: data_pin_in  = (seg_ff == sstwr_pkg::SEG_START);
                           2'd2: clock_pin_in = 1'b1;
                           default: data_pin_in = (seg_ff != sstwr_pkg::SEG_START);
                        endcase
                     end
                  endcase

                  // sequencing
                  off_in = off_ff + 5'd1;
                  ph_in  = (ph_ff == sstwr_pkg::PH_LAST) ? 2'd0 : ph_ff + 2'd1;
                  unique case (seg_ff)
                     sstwr_pkg::SEG_START: begin
                        if (off_ff == sstwr_pkg::COND_LAST) begin
                           seg_in = sstwr_pkg::SEG_BYTE;
                           off_in = 5'd0;
                           ph_in  = 2'd0;
                        end
                     end
                     sstwr_pkg::SEG_BYTE: begin
                        if (off_ff == sstwr_pkg::BYTE_LAST) begin
                           off_in = 5'd0;
                           ph_in  = 2'd0;
                           // refresh: stop after the data cmd and after the last digit
                           if (refresh_ff && byte_ff != 3'd0 && byte_ff != sstwr_pkg::LAST_BYTE)
                           begin
                              byte_in = byte_ff + 3'd1;
                           end else begin
                              seg_in = sstwr_pkg::SEG_STOP;
                           end
                        end
                     end
                     default: begin
                        if (off_ff == sstwr_pkg::COND_LAST) begin
                           off_in = 5'd0;
                           ph_in  = 2'd0;
                           if (refresh_ff && byte_ff == 3'd0) begin
                              seg_in  = sstwr_pkg::SEG_START;
                              byte_in = 3'd1;
                           end else begin
                              active_in = 1'b0;
                              done      = 1'b1;
                           end
                        end
                     end
                  endcase
               end
            end
            sstwr_pkg::ACT_WRITE: begin
               for (int i = 0; i < sstwr_pkg::DIGITS; i++) begin
                  if (req_digit_index == sstwr_pkg::INDEX_W'(i)) digit_in[i] = req_segments;
               end
            end
            default: begin
               // start of a frame, dropped while one is running
               if (!active_ff) begin
                  active_in  = 1'b1;
                  refresh_in = (req_action == sstwr_pkg::ACT_REFRESH);
                  seg_in     = sstwr_pkg::SEG_START;
                  off_in     = 5'd0;
                  ph_in      = 2'd0;
                  byte_in    = 3'd0;
               end
            end
         endcase
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_clk_in   = rsp_clk_ff;
      rsp_dio_in   = rsp_dio_ff;
      rsp_busy_in  = rsp_busy_ff;
      rsp_done_in  = rsp_done_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_clk_in   = clock_pin_in;
         rsp_dio_in   = data_pin_in;
         rsp_busy_in  = active_in;
         rsp_done_in  = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sstwr_pkg::DIGITS; i++) begin
            digit_ff[i] <= sstwr_pkg::DIGIT_RST;
         end
         clock_pin_ff <= 1'b1;
         data_pin_ff  <= 1'b1;
         active_ff    <= 1'b0;
         refresh_ff   <= 1'b0;
         seg_ff       <= sstwr_pkg::SEG_START;
         off_ff       <= 5'd0;
         ph_ff        <= 2'd0;
         byte_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < sstwr_pkg::DIGITS; i++) begin
            digit_ff[i] <= digit_in[i];
         end
         clock_pin_ff <= clock_pin_in;
         data_pin_ff  <= data_pin_in;
         active_ff    <= active_in;
         refresh_ff   <= refresh_in;
         seg_ff       <= seg_in;
         off_ff       <= off_in;
         ph_ff        <= ph_in;
         byte_ff      <= byte_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      rsp_clk_ff  <= rsp_clk_in;
      rsp_dio_ff  <= rsp_dio_in;
      rsp_busy_ff <= rsp_busy_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_clk_level  = rsp_clk_ff;
   assign rsp_dio_level  = rsp_dio_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule

// ===== hw/rtl/sstwr_checker.sv =====
// ============================================================================
// sstwr_checker
// Port-level checks on the refresher's request and response transactions.
// ============================================================================
module sstwr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_clk_level,
   input logic                            rsp_dio_level,
   input logic                            rsp_busy_res,
   input logic                            rsp_frame_done
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_clk_level)
         && $stable(rsp_dio_level) && $stable(rsp_busy_res) && $stable(rsp_frame_done))
      else $error("stalled response changed");

   // every accepted request yields a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // an empty response register never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked while response register empty");

   // last write of a frame leaves the block idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_busy_res)
      else $error("frame done while still busy");

   // frame end ends on a stop: clock and data both high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_clk_level && rsp_dio_level)
      else $error("frame ended with pins not idle");

endmodule

bind seven_segment_two_wire_refresher_top sstwr_checker u_sstwr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_clk_level  (rsp_clk_level),
   .rsp_dio_level  (rsp_dio_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_frame_done (rsp_frame_done)
);
